FILE: hw/rtl/pfla_pkg.sv
`default_nettype none

package pfla_pkg;

    localparam int CHUNK_W = 6;
    localparam int CNT_W   = 16;
    localparam int TOT_W   = 32;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_COLLECT = 2'd2;
    localparam logic [1:0] OP_PEAK    = 2'd3;

    localparam logic [2:0] ST_REUSED      = 3'd0;
    localparam logic [2:0] ST_HEAP_NEEDED = 3'd1;
    localparam logic [2:0] ST_FREED       = 3'd2;
    localparam logic [2:0] ST_RETURN      = 3'd3;
    localparam logic [2:0] ST_LIST_EMPTY  = 3'd4;
    localparam logic [2:0] ST_PEAK_RESET  = 3'd5;
    localparam logic [2:0] ST_FREE_ERROR  = 3'd6;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [CHUNK_W-1:0] chunk;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [CHUNK_W-1:0] chunk_out;
        logic               last;
        logic [CNT_W-1:0]   in_use_count;
        logic [CNT_W-1:0]   peak_in_use;
        logic [CNT_W-1:0]   global_peak;
        logic [CNT_W-1:0]   free_count;
        logic [TOT_W-1:0]   reuse_total;
        logic [TOT_W-1:0]   new_alloc_total;
    } out_word_t;

    typedef enum logic [2:0] {
        JOB_ALLOC,
        JOB_FREE,
        JOB_FREE_BAD,
        JOB_COLLECT,
        JOB_PEAK
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [CHUNK_W-1:0] chunk;
    } job_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        job_t job;
    } job_slot_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pfla_ram.sv
`default_nettype none

module pfla_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pfla_front.sv
`default_nettype none

module pfla_front #(
    parameter int NUM_CHUNKS = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire pfla_pkg::in_word_t  cmd,
    output logic                     busy,
    output pfla_pkg::job_slot_t      head,
    input  wire logic                pop
);

    import pfla_pkg::*;

    job_t              q_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     count_reg, count_next;
    logic              push;
    job_t              job_in;

    // classify: a free of a handle outside the pool is refused up front
    always_comb
    begin
        job_in.chunk = cmd.chunk;
        case (cmd.opcode)
            OP_ALLOC:   job_in.kind = JOB_ALLOC;
            OP_FREE:
            begin
                if ({1'b0, cmd.chunk} < (CHUNK_W+1)'(NUM_CHUNKS))
                    job_in.kind = JOB_FREE;
                else
                    job_in.kind = JOB_FREE_BAD;
            end
            OP_COLLECT: job_in.kind = JOB_COLLECT;
            OP_PEAK:    job_in.kind = JOB_PEAK;
            default:    job_in.kind = JOB_PEAK;
        endcase
    end

    assign busy      = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign push      = start && !busy;
    assign head.valid = (count_reg != '0);
    assign head.job   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pfla_back.sv
`default_nettype none

module pfla_back #(
    parameter int NUM_CHUNKS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pfla_pkg::job_slot_t  head,
    output logic                      pop,
    output logic                      done,
    output pfla_pkg::out_word_t       result
);

    import pfla_pkg::*;

    localparam int AW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int LW = CHUNK_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK
    } state_t;

    state_t             state_reg, state_next;
    logic [CHUNK_W-1:0] head_reg, head_next;
    logic               nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]   in_use_reg, in_use_next;
    logic [CNT_W-1:0]   peak_reg, peak_next;
    logic [CNT_W-1:0]   gpeak_reg, gpeak_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    logic [TOT_W-1:0]   reuse_reg, reuse_next;
    logic [TOT_W-1:0]   heap_reg, heap_next;
    logic [AW-1:0]      walk_reg, walk_next;
    logic               done_reg, done_next;
    out_word_t          result_reg, result_next;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [LW-1:0]      ram_wdata, ram_rdata;
    logic               link_end;
    logic [CHUNK_W-1:0] link;
    logic [CNT_W-1:0]   use_inc;
    logic               walk_final;
    logic [2:0]         st;
    logic [CHUNK_W-1:0] st_chunk;
    logic               st_last;
    logic               note_use;

    function automatic logic [CNT_W-1:0] inc16(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] dec16(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

    function automatic logic [TOT_W-1:0] inc32(input logic [TOT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    pfla_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_CHUNKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign link_end   = ram_rdata[LW-1];
    assign link       = ram_rdata[CHUNK_W-1:0];
    assign use_inc    = inc16(in_use_reg);
    assign walk_final = link_end || (walk_reg == AW'(NUM_CHUNKS - 1));

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        in_use_next   = in_use_reg;
        peak_next     = peak_reg;
        gpeak_next    = gpeak_reg;
        free_next     = free_reg;
        reuse_next    = reuse_reg;
        heap_next     = heap_reg;
        walk_next     = walk_reg;
        done_next     = 1'b0;
        pop           = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = head.job.chunk[AW-1:0];
        ram_wdata     = {!nonempty_reg, head_reg};
        ram_re        = 1'b0;
        ram_raddr     = head_reg[AW-1:0];
        st            = ST_FREE_ERROR;
        st_chunk      = '0;
        st_last       = 1'b1;
        note_use      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.job.kind)
                        JOB_ALLOC:
                        begin
                            if (nonempty_reg)
                            begin
                                ram_re     = 1'b1;
                                state_next = S_POP;
                            end
                            else
                            begin
                                heap_next = inc32(heap_reg);
                                note_use  = 1'b1;
                                st        = ST_HEAP_NEEDED;
                                done_next = 1'b1;
                            end
                        end
                        JOB_FREE:
                        begin
                            if (in_use_reg != '0)
                            begin
                                ram_we        = 1'b1;
                                head_next     = head.job.chunk;
                                nonempty_next = 1'b1;
                                in_use_next   = dec16(in_use_reg);
                                free_next     = inc16(free_reg);
                                st            = ST_FREED;
                                st_chunk      = head.job.chunk;
                            end
                            done_next = 1'b1;
                        end
                        JOB_COLLECT:
                        begin
                            if (nonempty_reg)
                            begin
                                ram_re     = 1'b1;
                                walk_next  = '0;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                st        = ST_LIST_EMPTY;
                                done_next = 1'b1;
                            end
                        end
                        JOB_PEAK:
                        begin
                            peak_next = in_use_reg;
                            st        = ST_PEAK_RESET;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (link_end)
                    nonempty_next = 1'b0;
                else
                    head_next = link;
                reuse_next = inc32(reuse_reg);
                free_next  = dec16(free_reg);
                note_use   = 1'b1;
                st         = ST_REUSED;
                st_chunk   = head_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (!link_end)
                    head_next = link;
                free_next = dec16(free_reg);
                st        = ST_RETURN;
                st_chunk  = head_reg;
                st_last   = walk_final;
                done_next = 1'b1;
                if (walk_final)
                begin
                    nonempty_next = 1'b0;
                    free_next     = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    // fetch the following link straight from the returned word
                    ram_re    = 1'b1;
                    ram_raddr = link[AW-1:0];
                    walk_next = walk_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (note_use)
        begin
            in_use_next = use_inc;
            if (use_inc > peak_reg)
                peak_next = use_inc;
            if (use_inc > gpeak_reg)
                gpeak_next = use_inc;
        end

        result_next.status          = st;
        result_next.chunk_out       = st_chunk;
        result_next.last            = st_last;
        result_next.in_use_count    = in_use_next;
        result_next.peak_in_use     = peak_next;
        result_next.global_peak     = gpeak_next;
        result_next.free_count      = free_next;
        result_next.reuse_total     = reuse_next;
        result_next.new_alloc_total = heap_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        walk_reg   <= walk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            in_use_reg   <= '0;
            peak_reg     <= '0;
            gpeak_reg    <= '0;
            free_reg     <= '0;
            reuse_reg    <= '0;
            heap_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            in_use_reg   <= in_use_next;
            peak_reg     <= peak_next;
            gpeak_reg    <= gpeak_next;
            free_reg     <= free_next;
            reuse_reg    <= reuse_next;
            heap_reg     <= heap_next;
            done_reg     <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pool_free_list_allocator_top.sv
// Channel   Ports                  Handshake
// command   start, cmd, busy       word taken when start && !busy
// result    done, result           word present for one cycle while done is high
//
// A command word enters a two-word queue; the execution side takes one word a cycle while idle.
// Free, reset-peak, heap-needed alloc and collect on an empty list finish from the idle state.
// Alloc from the list passes through a pop state, set by the registered read of the link memory.
// Collect starts the walk from the idle state, then returns one handle a cycle, up to NUM_CHUNKS.
// Reset clears the counters and the list head; the link memory is not cleared.
// busy rises only while the queue is full; results cannot be held off.
`default_nettype none

module pool_free_list_allocator_top #(
    parameter int NUM_CHUNKS = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire pfla_pkg::in_word_t  cmd,
    output logic                     busy,
    output logic                     done,
    output pfla_pkg::out_word_t      result
);

    import pfla_pkg::*;

    job_slot_t q_head;
    logic      q_pop;

    pfla_front #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .head  (q_head),
        .pop   (q_pop)
    );

    pfla_back #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .pop    (q_pop),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps

// Mirror of the pool: the linked free list, the usage counters and the result words still due.
class free_list_mirror;
    int unsigned pool_size;

    bit [5:0]  link_mem [64];
    bit        link_tail [64];
    bit [5:0]  head;
    bit        nonempty;
    bit [15:0] in_use;
    bit [15:0] peak;
    bit [15:0] global_peak;
    bit [15:0] free_total;
    bit [31:0] reuse_total;
    bit [31:0] heap_total;

    pfla_pkg::out_word_t awaited_words [$];

    int mismatches;
    int strays;
    int reported;
    int words_seen;
    int results_seen;
    int walks;
    int bounded_walks;
    int refused_frees;

    function new(int unsigned size);
        pool_size = size;
    endfunction

    function void record(logic [2:0] status, bit [5:0] handle, bit last_flag);
        pfla_pkg::out_word_t r;
        r.status          = status;
        r.chunk_out       = handle;
        r.last            = last_flag;
        r.in_use_count    = in_use;
        r.peak_in_use     = peak;
        r.global_peak     = global_peak;
        r.free_count      = free_total;
        r.reuse_total     = reuse_total;
        r.new_alloc_total = heap_total;
        awaited_words.push_back(r);
    endfunction

    function void take_chunk();
        if (in_use != 16'hFFFF)
            in_use++;
        if (in_use > peak)
            peak = in_use;
        if (in_use > global_peak)
            global_peak = in_use;
    endfunction

    function void note_word(pfla_pkg::in_word_t w);
        bit [5:0] h;
        int       n;
        bit       fin;
        words_seen++;
        case (w.opcode)
            pfla_pkg::OP_ALLOC:
            begin
                if (nonempty)
                begin
                    h = head;
                    if (link_tail[h])
                        nonempty = 1'b0;
                    else
                        head = link_mem[h];
                    if (reuse_total != 32'hFFFF_FFFF)
                        reuse_total++;
                    if (free_total != 16'd0)
                        free_total--;
                    take_chunk();
                    record(pfla_pkg::ST_REUSED, h, 1'b1);
                end
                else
                begin
                    if (heap_total != 32'hFFFF_FFFF)
                        heap_total++;
                    take_chunk();
                    record(pfla_pkg::ST_HEAP_NEEDED, 6'd0, 1'b1);
                end
            end
            pfla_pkg::OP_FREE:
            begin
                if (in_use == 16'd0 || int'(w.chunk) >= int'(pool_size))
                begin
                    refused_frees++;
                    record(pfla_pkg::ST_FREE_ERROR, 6'd0, 1'b1);
                end
                else
                begin
                    link_mem[w.chunk]  = head;
                    link_tail[w.chunk] = !nonempty;
                    head               = w.chunk;
                    nonempty           = 1'b1;
                    in_use--;
                    if (free_total != 16'hFFFF)
                        free_total++;
                    record(pfla_pkg::ST_FREED, w.chunk, 1'b1);
                end
            end
            pfla_pkg::OP_COLLECT:
            begin
                walks++;
                if (!nonempty)
                    record(pfla_pkg::ST_LIST_EMPTY, 6'd0, 1'b1);
                n = 0;
                while (nonempty && n < int'(pool_size))
                begin
                    h = head;
                    if (link_tail[h])
                        nonempty = 1'b0;
                    else
                        head = link_mem[h];
                    if (free_total != 16'd0)
                        free_total--;
                    fin = !nonempty || n == int'(pool_size) - 1;
                    // a walk cut short at the pool size drops whatever is left on the list
                    if (fin)
                    begin
                        if (nonempty)
                            bounded_walks++;
                        nonempty   = 1'b0;
                        free_total = 16'd0;
                    end
                    record(pfla_pkg::ST_RETURN, h, fin);
                    n++;
                end
            end
            default:
            begin
                peak = in_use;
                record(pfla_pkg::ST_PEAK_RESET, 6'd0, 1'b1);
            end
        endcase
    endfunction

    function void check_word(pfla_pkg::out_word_t got);
        pfla_pkg::out_word_t want;
        results_seen++;
        if (awaited_words.size() == 0)
        begin
            strays++;
            if (reported < 10)
            begin
                reported++;
                $display("result %0d arrived with nothing due: status %0d chunk %0d",
                         results_seen, got.status, got.chunk_out);
            end
            return;
        end
        want = awaited_words.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (reported < 10)
            begin
                reported++;
                $display("result %0d mismatch (status chunk last in_use peak gpeak free reuse heap)",
                         results_seen);
                $display("  expected %0d %0d %0d %0d %0d %0d %0d %0d %0d", want.status,
                         want.chunk_out, want.last, want.in_use_count, want.peak_in_use,
                         want.global_peak, want.free_count, want.reuse_total,
                         want.new_alloc_total);
                $display("  actual   %0d %0d %0d %0d %0d %0d %0d %0d %0d", got.status,
                         got.chunk_out, got.last, got.in_use_count, got.peak_in_use,
                         got.global_peak, got.free_count, got.reuse_total,
                         got.new_alloc_total);
            end
        end
    endfunction

    function int failures();
        return mismatches + strays + awaited_words.size();
    endfunction
endclass

module testbench;
    import pfla_pkg::*;

    localparam int POOL_SIZE     = 64;
    localparam int SETTLE_CYCLES = 8;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_word_t  cmd   = '0;
    logic      busy;
    logic      done;
    out_word_t result;

    free_list_mirror mirror;

    always #2 clk = ~clk;

    pool_free_list_allocator_top #(
        .NUM_CHUNKS(POOL_SIZE)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .result(result)
    );

    initial
    begin
        #3_000_000;
        $display("testbench failed");
        $finish;
    end

    // check before noting: a word taken at this edge cannot own a result on the same edge
    always @(posedge clk)
    begin
        if (rst_n && mirror != null)
        begin
            if (done)
                mirror.check_word(result);
            if (start && !busy)
                mirror.note_word(cmd);
        end
    end

    task automatic send(input logic [1:0] op, input logic [5:0] ch);
        start <= 1'b1;
        cmd   <= '{opcode: op, chunk: ch};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        cmd   <= '{opcode: 2'($urandom_range(0, 3)), chunk: 6'($urandom_range(0, 63))};
        repeat (cycles)
            @(posedge clk);
    endtask

    // hold off until every due word is back, then let the block fall quiet
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (mirror.awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic random_words(input int count, input bit calm);
        int         mode;
        int         r;
        logic [1:0] op;
        for (int i = 0; i < count; i++)
        begin
            if (!calm && $urandom_range(0, 3) == 0)
                pause($urandom_range(1, 5));
            // cycle through growing, shrinking and balanced stretches of traffic
            mode = (i / 40) % 3;
            r    = $urandom_range(0, 99);
            case (mode)
                0:       op = (r < 55) ? OP_ALLOC : (r < 85) ? OP_FREE :
                              (r < 90) ? OP_COLLECT : OP_PEAK;
                1:       op = (r < 15) ? OP_ALLOC : (r < 85) ? OP_FREE :
                              (r < 90) ? OP_COLLECT : OP_PEAK;
                default: op = (r < 40) ? OP_ALLOC : (r < 80) ? OP_FREE :
                              (r < 90) ? OP_COLLECT : OP_PEAK;
            endcase
            send(op, 6'($urandom_range(0, 63)));
        end
    endtask

    initial
    begin
        mirror = new(POOL_SIZE);
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, refused free, peak reset at zero
        send(OP_COLLECT, 6'd0);
        send(OP_FREE, 6'd63);
        send(OP_PEAK, 6'd21);
        send(OP_ALLOC, 6'd42);
        send(OP_ALLOC, 6'd0);
        send(OP_ALLOC, 6'd63);
        // freeing 63 twice links it to itself
        send(OP_FREE, 6'd0);
        send(OP_FREE, 6'd63);
        send(OP_FREE, 6'd63);
        send(OP_FREE, 6'd21);
        // pop past the free count so it pins at zero
        send(OP_ALLOC, 6'd0);
        send(OP_ALLOC, 6'd0);
        send(OP_ALLOC, 6'd0);
        send(OP_ALLOC, 6'd0);
        send(OP_FREE, 6'd21);
        send(OP_PEAK, 6'd0);
        // the loop makes the walk run to the pool size
        send(OP_COLLECT, 6'd63);
        send(OP_ALLOC, 6'd0);
        send(OP_FREE, 6'd42);
        send(OP_FREE, 6'd21);
        send(OP_ALLOC, 6'd0);
        send(OP_ALLOC, 6'd0);
        send(OP_FREE, 6'd0);
        send(OP_COLLECT, 6'd0);

        random_words(280, 1'b0);
        random_words(70, 1'b1);

        // drain the list, then rebuild a short one and drain it again
        settle();
        send(OP_COLLECT, 6'd0);
        settle();
        send(OP_FREE, 6'd5);
        send(OP_FREE, 6'd5);
        send(OP_PEAK, 6'd0);
        send(OP_ALLOC, 6'd0);
        send(OP_ALLOC, 6'd0);
        send(OP_ALLOC, 6'd0);
        send(OP_FREE, 6'd58);
        send(OP_COLLECT, 6'd0);
        settle();

        $display("%0d command words, %0d results, %0d collect walks (%0d cut at the pool size)",
                 mirror.words_seen, mirror.results_seen, mirror.walks, mirror.bounded_walks);
        $display("%0d refused frees; global peak %0d",
                 mirror.refused_frees, mirror.global_peak);
        if (mirror.failures() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
